/* rtl/core/assert_macros.svh */
// assertion macros shared by the core modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock outside reset
`define KMS_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define KMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kms_pkg.sv */
// shared types, constants and base mapping for the minimizer core
// no dependencies
package kms_pkg;

    localparam int DEF_MAX_KMER_LEN = 64;
    localparam int DEF_MAX_MMER_LEN = 32;
    localparam int DEF_POS_BITS     = 16;

    localparam int SEEN_W   = 17;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
    localparam int CODE_W   = 3;
    localparam int WORD_W   = 64;
    localparam int Q_DEPTH  = 4;
    localparam int IDX_W    = 8;

    localparam logic [IDX_W-1:0] REG_KMER_LEN    = 8'd0;
    localparam logic [IDX_W-1:0] REG_MIN_LEN     = 8'd1;
    localparam logic [IDX_W-1:0] REG_CODE_SEED   = 8'd2;
    localparam logic [IDX_W-1:0] REG_MIN_CEILING = 8'd3;

    localparam logic [6:0] RST_KMER_LEN = 7'd31;
    localparam logic [5:0] RST_MIN_LEN  = 6'd15;

    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [6:0]        kmer_len;
        logic [5:0]        min_len;
        logic [WORD_W-1:0] code_seed;
        logic [WORD_W-1:0] min_ceiling;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MMER,
        ST_SCAN,
        ST_OUT
    } st_t;

    function automatic logic [CODE_W-1:0] map_base(input logic [7:0] ch);
        logic [CODE_W-1:0] c;
        unique case (ch)
            8'h41, 8'h61: c = CODE_A;
            8'h43, 8'h63: c = CODE_C;
            8'h47, 8'h67: c = CODE_G;
            8'h54, 8'h74: c = CODE_T;
            default:      c = CODE_OTHER;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/kms_front.sv */
// front end: accepts bases, maps them to codes and queues them
// depends on kms_pkg and assert_macros.svh
`include "assert_macros.svh"
module kms_front
    import kms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] base
    input  logic       s_tlast,   // read_end
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    item_t           q_mem [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            push;

    assign s_tready = (cnt_reg != CNTW'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{code: map_base(s_tdata), last: s_tlast};
        end
    end

    `KMS_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNTW'(Q_DEPTH), "queue count overflow")
    `KMS_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, q_pop, cnt_reg != '0, "pop from empty queue")

endmodule

/* rtl/core/kms_back.sv */
// back end: per-base m-mer code build and sliding minimum scan
// depends on kms_pkg and assert_macros.svh
`include "assert_macros.svh"
module kms_back
    import kms_pkg::*;
#(
    parameter int MAX_KMER_LEN = DEF_MAX_KMER_LEN,
    parameter int MAX_MMER_LEN = DEF_MAX_MMER_LEN,
    parameter int POS_BITS     = DEF_POS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_minimizer,
    output logic [POS_BITS-1:0] m_kmer_start
);

    localparam int SW   = (MAX_KMER_LEN > 1) ? $clog2(MAX_KMER_LEN) : 1;
    localparam int NW   = $clog2(MAX_KMER_LEN + 1);
    localparam int MW   = $clog2(MAX_MMER_LEN + 1);
    localparam int CW   = (NW > MW) ? NW : MW;
    localparam logic [31:0] POS_MAX = 32'((64'(1) << POS_BITS) - 64'(1));

    logic [CODE_W-1:0] base_mem [MAX_KMER_LEN];
    logic [WORD_W-1:0] mmer_mem [MAX_KMER_LEN];
    logic [CODE_W-1:0] bc_rd_reg;
    logic [WORD_W-1:0] mm_rd_reg;

    st_t               st_reg, st_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [SW-1:0]     wslot_reg, wslot_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [SW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic              pend_reg, pend_next;
    logic [6:0]        sh_reg, sh_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic              do_out_reg, do_out_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0] min_out_reg, min_out_next;
    logic [POS_BITS-1:0] pos_out_reg, pos_out_next;
    logic              base_we, mm_we;

    logic [SEEN_W-1:0] k_raw, m_raw, kc, mc, seen_inc;
    logic [31:0]       diff;
    logic [SW-1:0]     ptr_dec;

    assign k_raw = SEEN_W'(cfg.kmer_len);
    assign m_raw = SEEN_W'(cfg.min_len);
    assign kc = (k_raw < SEEN_W'(2)) ? SEEN_W'(2) :
                (k_raw > SEEN_W'(MAX_KMER_LEN)) ? SEEN_W'(MAX_KMER_LEN) : k_raw;
    assign mc = (m_raw < SEEN_W'(1)) ? SEEN_W'(1) :
                (m_raw > SEEN_W'(MAX_MMER_LEN)) ? SEEN_W'(MAX_MMER_LEN) : m_raw;
    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
    assign diff     = 32'(seen_inc) - 32'(kc);
    assign ptr_dec  = (ptr_reg == '0) ? SW'(MAX_KMER_LEN - 1) : ptr_reg - 1'b1;

    assign m_tvalid     = m_tvalid_reg;
    assign m_minimizer  = min_out_reg;
    assign m_kmer_start = pos_out_reg;

    always_comb begin
        st_next       = st_reg;
        seen_next     = seen_reg;
        wslot_next    = wslot_reg;
        slot_next     = slot_reg;
        ptr_next      = ptr_reg;
        iss_next      = iss_reg;
        lim_next      = lim_reg;
        pend_next     = 1'b0;
        sh_next       = sh_reg;
        acc_next      = acc_reg;
        do_out_next   = do_out_reg;
        start_next    = start_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        min_out_next  = min_out_reg;
        pos_out_next  = pos_out_reg;
        q_pop         = 1'b0;
        base_we       = 1'b0;
        mm_we         = 1'b0;

        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    base_we     = 1'b1;
                    slot_next   = wslot_reg;
                    ptr_next    = wslot_reg;
                    iss_next    = '0;
                    lim_next    = CW'(mc);
                    acc_next    = cfg.code_seed << {mc[5:0], 1'b0};
                    do_out_next = (mc <= kc) && (seen_inc >= kc);
                    start_next  = (diff > POS_MAX) ? POS_MAX[POS_BITS-1:0]
                                                   : diff[POS_BITS-1:0];
                    if (q_item.last) begin
                        seen_next  = '0;
                        wslot_next = '0;
                    end else begin
                        seen_next  = seen_inc;
                        wslot_next = (wslot_reg == SW'(MAX_KMER_LEN - 1)) ? '0
                                                                         : wslot_reg + 1'b1;
                    end
                    if (seen_inc >= mc) begin
                        st_next = ST_MMER;
                    end
                end
            end
            ST_MMER: begin
                // oldest-first shift and or equals or of each code at twice its age
                if (pend_reg) begin
                    acc_next = acc_reg | (WORD_W'(bc_rd_reg) << sh_reg);
                end
                if (iss_reg != lim_reg) begin
                    ptr_next  = ptr_dec;
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                    sh_next   = 7'({iss_reg, 1'b0});
                end else if (!pend_reg) begin
                    mm_we = 1'b1;
                    if (do_out_reg) begin
                        st_next  = ST_SCAN;
                        ptr_next = slot_reg;
                        iss_next = '0;
                        lim_next = CW'(kc - mc + 1'b1);
                        acc_next = cfg.min_ceiling;
                    end else begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg && (mm_rd_reg < acc_reg)) begin
                    acc_next = mm_rd_reg;
                end
                if (iss_reg != lim_reg) begin
                    ptr_next  = ptr_dec;
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    min_out_next  = acc_reg;
                    pos_out_next  = start_reg;
                    st_next       = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            seen_reg     <= '0;
            wslot_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            iss_reg      <= '0;
            lim_reg      <= '0;
        end else begin
            st_reg       <= st_next;
            seen_reg     <= seen_next;
            wslot_reg    <= wslot_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            iss_reg      <= iss_next;
            lim_reg      <= lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg    <= slot_next;
        ptr_reg     <= ptr_next;
        sh_reg      <= sh_next;
        acc_reg     <= acc_next;
        do_out_reg  <= do_out_next;
        start_reg   <= start_next;
        min_out_reg <= min_out_next;
        pos_out_reg <= pos_out_next;
    end

    always_ff @(posedge aclk) begin
        bc_rd_reg <= base_mem[ptr_reg];
        mm_rd_reg <= mmer_mem[ptr_reg];
        if (base_we) begin
            base_mem[wslot_reg] <= q_item.code;
        end
        if (mm_we) begin
            mmer_mem[slot_reg] <= acc_reg;
        end
    end

    `KMS_ASSERT(a_iss_bound, aclk, aresetn, iss_reg <= lim_reg, "read issue count past limit")
    `KMS_ASSERT_IMP(a_out_src, aclk, aresetn, $rose(m_tvalid_reg), $past(st_reg == ST_OUT), "result not from output state")
    `KMS_ASSERT_IMP(a_pend_src, aclk, aresetn, pend_reg, $past(st_reg == ST_MMER) || $past(st_reg == ST_SCAN), "stray read data")

endmodule

/* rtl/core/kmer_minimizer_stream_core.sv */
// channel   | dir | handshake            | payload
// s_        | in  | s_tvalid / s_tready  | s_tdata base, s_tlast read_end
// m_        | out | m_tvalid / m_tready  | m_tdata minimizer, kmer_start
// cfg_      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
// a base that gives a result makes m reads of the base-code
// memory, then k - m + 1 reads of the m-mer memory, one read port each
// a base that gives no result makes only the m reads, or none before m bases are in
// synchronous active-low reset; a four-entry queue keeps accepting while the back end works
// a waiting result stalls only the final step of the next result
// depends on kms_pkg, kms_front, kms_back
module kmer_minimizer_stream_core
    import kms_pkg::*;
#(
    parameter int MAX_KMER_LEN = DEF_MAX_KMER_LEN,
    parameter int MAX_MMER_LEN = DEF_MAX_MMER_LEN,
    parameter int POS_BITS     = DEF_POS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] base
    input  logic                s_tlast,   // read_end
    output logic                m_tvalid,
    input  logic                m_tready,
    // minimizer [63:0], kmer_start above it, zero pad to bytes
    output logic [((WORD_W + POS_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]   cfg_data
);

    localparam int OUT_W = ((WORD_W + POS_BITS + 7) / 8) * 8;

    cfg_t                cfg_reg;
    logic                q_valid, q_pop;
    item_t               q_item;
    logic [WORD_W-1:0]   minimizer;
    logic [POS_BITS-1:0] kmer_start;

    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_W'({kmer_start, minimizer});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kmer_len    <= RST_KMER_LEN;
            cfg_reg.min_len     <= RST_MIN_LEN;
            cfg_reg.code_seed   <= '0;
            cfg_reg.min_ceiling <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KMER_LEN:    cfg_reg.kmer_len    <= cfg_data[6:0];
                REG_MIN_LEN:     cfg_reg.min_len     <= cfg_data[5:0];
                REG_CODE_SEED:   cfg_reg.code_seed   <= cfg_data;
                REG_MIN_CEILING: cfg_reg.min_ceiling <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    kms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    kms_back #(
        .MAX_KMER_LEN (MAX_KMER_LEN),
        .MAX_MMER_LEN (MAX_MMER_LEN),
        .POS_BITS     (POS_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_minimizer  (minimizer),
        .m_kmer_start (kmer_start)
    );

endmodule

/* verif/tb_kmer_minimizer_stream_core.sv */
// self-checking bench for kmer_minimizer_stream_core: random and directed reads, checked per result
// depends on kms_pkg and the core rtl
`timescale 1ns / 1ps

module tb_kmer_minimizer_stream_core;
    import kms_pkg::*;

    localparam int MAXK = DEF_MAX_KMER_LEN;
    localparam int MAXM = DEF_MAX_MMER_LEN;
    localparam int PB   = DEF_POS_BITS;
    localparam int MW   = ((WORD_W + PB + 7) / 8) * 8;

    typedef struct packed {
        logic [7:0] base;
        logic       read_end;
    } base_req_t;

    typedef struct packed {
        logic [PB-1:0]     kmer_start;
        logic [WORD_W-1:0] minimizer;
    } mini_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    kmer_minimizer_stream_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [6:0]        p_kmer_len = RST_KMER_LEN;
    logic [5:0]        p_min_len = RST_MIN_LEN;
    logic [WORD_W-1:0] p_seed = '0;
    logic [WORD_W-1:0] p_ceiling = '1;
    logic [CODE_W-1:0] p_codes [MAXK];
    logic [WORD_W-1:0] p_mmers [MAXK];
    int unsigned       p_seen = 0;
    int unsigned       p_slot = 0;

    base_req_t pending_bases[$];
    mini_t     expected_minis[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_bases = 0;

    // handshakes seen at the last rising edge
    bit        s_fire = 1'b0;
    bit        m_fire = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic logic [CODE_W-1:0] code_of(input logic [7:0] ch);
        case (ch)
            "A", "a": return CODE_A;
            "C", "c": return CODE_C;
            "G", "g": return CODE_G;
            "T", "t": return CODE_T;
            default:  return CODE_OTHER;
        endcase
    endfunction

    task automatic predict_minimizer(input base_req_t r);
        int unsigned k, m, slot, st;
        logic [WORD_W-1:0] code, best;
        mini_t res;
        k = p_kmer_len < 2 ? 2 : (p_kmer_len > MAXK ? MAXK : p_kmer_len);
        m = p_min_len < 1 ? 1 : (p_min_len > MAXM ? MAXM : p_min_len);
        slot = p_slot % MAXK;
        p_codes[slot] = code_of(r.base);
        if (p_seen < 131071) p_seen++;
        if (p_seen >= m) begin
            code = p_seed;
            for (int j = m; j > 0; j--)
                code = (code << 2) | WORD_W'(p_codes[(slot + MAXK - (j - 1)) % MAXK]);
            p_mmers[slot] = code;
        end
        if (m <= k && p_seen >= k) begin
            best = p_ceiling;
            for (int j = 0; j <= int'(k - m); j++)
                if (p_mmers[(slot + MAXK - j) % MAXK] < best)
                    best = p_mmers[(slot + MAXK - j) % MAXK];
            st = p_seen - k;
            if (st > (1 << PB) - 1) st = (1 << PB) - 1;
            res.minimizer = best;
            res.kmer_start = st[PB-1:0];
            expected_minis.push_back(res);
        end
        p_slot = (slot + 1) % MAXK;
        if (r.read_end) begin
            p_seen = 0;
            p_slot = 0;
        end
    endtask

    // driver
    int s_gap = 0;
    int m_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                s_gap = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) s_gap = 0;
            end
            if (!s_tvalid || s_fire) begin
                if (s_gap > 0 || pending_bases.size() == 0) begin
                    if (s_gap > 0) s_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    base_req_t r;
                    r = pending_bases.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= r.base;
                    s_tlast <= r.read_end;
                end
            end
            if (m_fire) m_gap = $urandom_range(0, 4);
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                base_req_t r;
                r.base = s_tdata;
                r.read_end = s_tlast;
                predict_minimizer(r);
                n_bases++;
            end
            if (m_tvalid && m_tready) begin
                mini_t got, want;
                got = mini_t'(m_tdata[WORD_W+PB-1:0]);
                n_results++;
                if (expected_minis.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = expected_minis.pop_front();
                    if (got.minimizer !== want.minimizer)
                        report_mismatch($sformatf("minimizer %h expected %h",
                                                  got.minimizer, want.minimizer));
                    if (got.kmer_start !== want.kmer_start)
                        report_mismatch($sformatf("kmer_start %0d expected %0d",
                                                  got.kmer_start, want.kmer_start));
                end
            end
        end
    end

    // tail covers up to five queued bases that give no result
    task automatic wait_drained();
        while (pending_bases.size() != 0 || s_tvalid || expected_minis.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_KMER_LEN:    p_kmer_len = val[6:0];
            REG_MIN_LEN:     p_min_len = val[5:0];
            REG_CODE_SEED:   p_seed = val;
            REG_MIN_CEILING: p_ceiling = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_base();
        logic [7:0] acgt [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return acgt[$urandom_range(0, 7)];
    endfunction

    // a read always starts fresh, so every m-mer slot it reads was written in it
    task automatic queue_read(input int len);
        base_req_t r;
        for (int i = 0; i < len; i++) begin
            r.base = rand_base();
            r.read_end = (i == len - 1);
            pending_bases.push_back(r);
        end
    endtask

    task automatic setup(input int k, input int m, input logic [63:0] seed,
                         input logic [63:0] ceil);
        write_reg(REG_KMER_LEN, 64'(k));
        write_reg(REG_MIN_LEN, 64'(m));
        write_reg(REG_CODE_SEED, seed);
        write_reg(REG_MIN_CEILING, ceil);
    endtask

    initial begin
        base_req_t r;
        int sent;
        logic [31:0] acgt_w;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, every byte class and bit patterns
        acgt_w = "ACGT";
        r.read_end = 1'b0;
        for (int i = 0; i < 20; i++) begin
            r.base = (i < 8) ? (8'h1 << i) :
                     ((i < 16) ? ~(8'h1 << (i - 8)) : acgt_w[(i % 4) * 8 +: 8]);
            r.read_end = (i == 19);
            pending_bases.push_back(r);
        end
        wait_drained();
        // read of exactly k, m equal k, m above k, out-of-range clamps
        setup(4, 2, 64'h0, '1);
        queue_read(4);
        wait_drained();
        setup(3, 3, '1, 64'h5);
        queue_read(5);
        wait_drained();
        setup(2, 5, 64'h0, '1);
        queue_read(6);
        wait_drained();
        setup(0, 0, 64'h8000_0000_0000_0001, '1);
        queue_read(4);
        wait_drained();
        setup(127, 63, 64'h0, 64'hffff_0000_0000_0000);
        queue_read(70);
        wait_drained();

        // random phases
        sent = 0;
        while (sent < 480) begin
            int k, m;
            k = $urandom_range(0, 5) == 0 ? $urandom_range(33, 127) : $urandom_range(0, 12);
            m = $urandom_range(0, 6) == 0 ? $urandom_range(0, 63) : $urandom_range(0, k + 1);
            setup(k, m, {$urandom, $urandom}, $urandom_range(0, 3) == 0 ?
                  {$urandom, $urandom} : '1);
            for (int rd = 0; rd < 4; rd++) begin
                int len;
                len = $urandom_range(1, (k > 20 ? 80 : 24));
                queue_read(len);
                sent += len;
            end
            wait_drained();
        end
        $display("covered %0d bases and %0d results over directed and random settings",
                 n_bases, n_results);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/kms_pkg.sv
rtl/core/kms_front.sv
rtl/core/kms_back.sv
rtl/core/kmer_minimizer_stream_core.sv
verif/tb_kmer_minimizer_stream_core.sv
